// ===== hw/rtl/awcf_pkg.sv =====
// Shared types and constants for the condition-flag ALU.
package awcf_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned ShW    = 6;
  localparam int unsigned FlagW  = 4;
  localparam int unsigned InTdataW  = 152;
  localparam int unsigned OutTdataW = 72;

  localparam logic [DataW-1:0] HalfMask = 64'h0000_0000_0000_FFFF;

  // Flag bit positions within NZCV
  localparam int unsigned FlagNBit = 3;
  localparam int unsigned FlagZBit = 2;
  localparam int unsigned FlagCBit = 1;
  localparam int unsigned FlagVBit = 0;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_ORN   = 5'd2,
    OP_OR    = 5'd3,
    OP_XOR   = 5'd4,
    OP_AND   = 5'd5,
    OP_MOV   = 5'd6,
    OP_MOVK  = 5'd7,
    OP_LSL   = 5'd8,
    OP_LSR   = 5'd9,
    OP_ASR   = 5'd10,
    OP_PASS  = 5'd11,
    OP_CSEL  = 5'd12,
    OP_CSINV = 5'd13,
    OP_CSINC = 5'd14,
    OP_CSNEG = 5'd15,
    OP_CBZ   = 5'd16,
    OP_CBNZ  = 5'd17
  } op_e;

  // Condition groups, taken from cond_code[3:1]; cond_code[0] inverts
  typedef enum logic [2:0] {
    CG_EQ = 3'd0,
    CG_CS = 3'd1,
    CG_MI = 3'd2,
    CG_VS = 3'd3,
    CG_HI = 3'd4,
    CG_GE = 3'd5,
    CG_GT = 3'd6,
    CG_AL = 3'd7
  } cond_grp_e;

  // Result source chosen in the compute stage
  typedef enum logic [1:0] {
    SRC_ADDER = 2'd0,
    SRC_SHIFT = 2'd1,
    SRC_MISC  = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    SHK_LSL = 2'd0,
    SHK_LSR = 2'd1,
    SHK_ASR = 2'd2
  } shk_e;

  // Decode stage output
  typedef struct packed {
    src_e             src;
    shk_e             shk;
    logic             arith;
    logic [DataW-1:0] add_x;
    logic [DataW-1:0] add_y;
    logic             add_cin;
    logic [DataW-1:0] misc;
    logic [DataW-1:0] opa;
    logic [ShW-1:0]   sh;
    logic             flag_en;
    logic             cond_true;
    logic [FlagW-1:0] flags_in;
  } dec_t;

  // Compute stage output
  typedef struct packed {
    logic [DataW-1:0] result;
    logic             carry;
    logic             ovf;
    logic             arith;
    logic             flag_en;
    logic             cond_true;
    logic [FlagW-1:0] flags_in;
  } exe_t;

endpackage

// ===== hw/rtl/alu_with_condition_flags.sv =====
// Three-stage 64-bit ALU with NZCV condition flags and stream handshakes.
// Throughput: one item per cycle; each stage holds its item while the next is full.
// Stages: decode and operand prep, 64-bit add/shift, zero test and flag merge.
// Reset: rst_ni (async, active low) clears all stage valid bits; payload is not reset.
module alu_with_condition_flags (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // op[4:0], operand_a[68:5], operand_b[132:69], halfword_shift[138:133],
  // flag_en[139], cond_code[143:140], flags_in[147:144], zero pad[151:148]
  input  logic [awcf_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // result[63:0], cond_true[64], flags_out[68:65], zero pad[71:69]
  output logic [awcf_pkg::OutTdataW-1:0]  m_axis_tdata_o
);

  // Input fields
  logic [4:0]                     in_op;
  logic [awcf_pkg::DataW-1:0]     in_a;
  logic [awcf_pkg::DataW-1:0]     in_b;
  logic [awcf_pkg::ShW-1:0]       in_hw;
  logic                           in_setf;
  logic [3:0]                     in_cond;
  logic [awcf_pkg::FlagW-1:0]     in_flags;

  assign in_op    = s_axis_tdata_i[4:0];
  assign in_a     = s_axis_tdata_i[68:5];
  assign in_b     = s_axis_tdata_i[132:69];
  assign in_hw    = s_axis_tdata_i[138:133];
  assign in_setf  = s_axis_tdata_i[139];
  assign in_cond  = s_axis_tdata_i[143:140];
  assign in_flags = s_axis_tdata_i[147:144];

  // Stage handshakes
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  // ---------------- Stage 1: decode ----------------
  awcf_pkg::dec_t dec_d, dec_q;
  logic           cond_raw;
  logic           cond_hit;
  logic [awcf_pkg::DataW-1:0] mov_b;
  logic [awcf_pkg::DataW-1:0] mov_mask;
  awcf_pkg::op_e  op_dec;
  logic n_f, z_f, c_f, v_f;

  assign n_f = in_flags[awcf_pkg::FlagNBit];
  assign z_f = in_flags[awcf_pkg::FlagZBit];
  assign c_f = in_flags[awcf_pkg::FlagCBit];
  assign v_f = in_flags[awcf_pkg::FlagVBit];

  always_comb begin
    unique case (awcf_pkg::cond_grp_e'(in_cond[3:1]))
      awcf_pkg::CG_EQ: cond_raw = z_f;
      awcf_pkg::CG_CS: cond_raw = c_f;
      awcf_pkg::CG_MI: cond_raw = n_f;
      awcf_pkg::CG_VS: cond_raw = v_f;
      awcf_pkg::CG_HI: cond_raw = c_f && !z_f;
      awcf_pkg::CG_GE: cond_raw = (n_f == v_f);
      awcf_pkg::CG_GT: cond_raw = !z_f && (n_f == v_f);
      default:         cond_raw = 1'b1;
    endcase
    // AL and NV both hold
    if (awcf_pkg::cond_grp_e'(in_cond[3:1]) == awcf_pkg::CG_AL) begin
      cond_hit = 1'b1;
    end else begin
      cond_hit = in_cond[0] ? !cond_raw : cond_raw;
    end
  end

  assign mov_b    = in_b << in_hw;
  assign mov_mask = ~(awcf_pkg::HalfMask << in_hw);
  assign op_dec   = awcf_pkg::op_e'(in_op);

  always_comb begin
    dec_d.src       = awcf_pkg::SRC_MISC;
    dec_d.shk       = awcf_pkg::SHK_LSL;
    dec_d.arith     = 1'b0;
    dec_d.add_x     = in_a;
    dec_d.add_y     = '0;
    dec_d.add_cin   = 1'b0;
    dec_d.misc      = '0;
    dec_d.opa       = in_a;
    dec_d.sh        = in_b[awcf_pkg::ShW-1:0];
    dec_d.flag_en   = in_setf;
    dec_d.cond_true = cond_hit;
    dec_d.flags_in  = in_flags;
    unique case (op_dec) inside
      awcf_pkg::OP_ADD: begin
        dec_d.src   = awcf_pkg::SRC_ADDER;
        dec_d.arith = 1'b1;
        dec_d.add_y = in_b;
      end
      awcf_pkg::OP_SUB: begin
        dec_d.src     = awcf_pkg::SRC_ADDER;
        dec_d.arith   = 1'b1;
        dec_d.add_y   = ~in_b;
        dec_d.add_cin = 1'b1;
      end
      awcf_pkg::OP_ORN:  dec_d.misc = in_a | ~in_b;
      awcf_pkg::OP_OR:   dec_d.misc = in_a | in_b;
      awcf_pkg::OP_XOR:  dec_d.misc = in_a ^ in_b;
      awcf_pkg::OP_AND:  dec_d.misc = in_a & in_b;
      awcf_pkg::OP_MOV:  dec_d.misc = in_a | mov_b;
      awcf_pkg::OP_MOVK: dec_d.misc = (in_a & mov_mask) | mov_b;
      awcf_pkg::OP_LSL: begin
        dec_d.src = awcf_pkg::SRC_SHIFT;
        dec_d.shk = awcf_pkg::SHK_LSL;
      end
      awcf_pkg::OP_LSR: begin
        dec_d.src = awcf_pkg::SRC_SHIFT;
        dec_d.shk = awcf_pkg::SHK_LSR;
      end
      awcf_pkg::OP_ASR: begin
        dec_d.src = awcf_pkg::SRC_SHIFT;
        dec_d.shk = awcf_pkg::SHK_ASR;
      end
      awcf_pkg::OP_PASS: dec_d.misc = in_a;
      awcf_pkg::OP_CSEL, awcf_pkg::OP_CSINV,
      awcf_pkg::OP_CSINC, awcf_pkg::OP_CSNEG: begin
        // Route every select through the adder: a+0, b+0, ~b+0, b+1 or ~b+1
        dec_d.src = awcf_pkg::SRC_ADDER;
        if (!cond_hit) begin
          dec_d.add_x   = (op_dec == awcf_pkg::OP_CSINV || op_dec == awcf_pkg::OP_CSNEG)
                          ? ~in_b : in_b;
          dec_d.add_cin = (op_dec == awcf_pkg::OP_CSINC || op_dec == awcf_pkg::OP_CSNEG);
        end
      end
      awcf_pkg::OP_CBZ: begin
        dec_d.misc      = in_a;
        dec_d.cond_true = (in_a == '0);
      end
      awcf_pkg::OP_CBNZ: begin
        dec_d.misc      = in_a;
        dec_d.cond_true = (in_a != '0);
      end
      default: dec_d.misc = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid_i) begin
      dec_q <= dec_d;
    end
  end

  // ---------------- Stage 2: add and shift ----------------
  awcf_pkg::exe_t exe_d, exe_q;
  logic [awcf_pkg::DataW:0]   sum_ext;
  logic [awcf_pkg::DataW-1:0] sum;
  logic [awcf_pkg::DataW-1:0] shv;

  assign sum_ext = {1'b0, dec_q.add_x} + {1'b0, dec_q.add_y}
                 + {{awcf_pkg::DataW{1'b0}}, dec_q.add_cin};
  assign sum     = sum_ext[awcf_pkg::DataW-1:0];

  always_comb begin
    case (dec_q.shk)
      awcf_pkg::SHK_LSR: shv = dec_q.opa >> dec_q.sh;
      awcf_pkg::SHK_ASR: shv = $unsigned($signed(dec_q.opa) >>> dec_q.sh);
      default:           shv = dec_q.opa << dec_q.sh;
    endcase
  end

  always_comb begin
    case (dec_q.src)
      awcf_pkg::SRC_ADDER: exe_d.result = sum;
      awcf_pkg::SRC_SHIFT: exe_d.result = shv;
      default:             exe_d.result = dec_q.misc;
    endcase
    exe_d.carry     = sum_ext[awcf_pkg::DataW];
    exe_d.ovf       = (dec_q.add_x[awcf_pkg::DataW-1] ^ sum[awcf_pkg::DataW-1])
                    & (dec_q.add_y[awcf_pkg::DataW-1] ^ sum[awcf_pkg::DataW-1]);
    exe_d.arith     = dec_q.arith;
    exe_d.flag_en   = dec_q.flag_en;
    exe_d.cond_true = dec_q.cond_true;
    exe_d.flags_in  = dec_q.flags_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      exe_q <= exe_d;
    end
  end

  // ---------------- Stage 3: flags ----------------
  logic [awcf_pkg::FlagW-1:0]     flags_d;
  logic [awcf_pkg::OutTdataW-1:0] out_d, out_q;

  always_comb begin
    if (exe_q.flag_en) begin
      flags_d                     = '0;
      flags_d[awcf_pkg::FlagNBit] = exe_q.result[awcf_pkg::DataW-1];
      flags_d[awcf_pkg::FlagZBit] = (exe_q.result == '0);
      flags_d[awcf_pkg::FlagCBit] = exe_q.arith && exe_q.carry;
      flags_d[awcf_pkg::FlagVBit] = exe_q.arith && exe_q.ovf;
    end else begin
      flags_d = exe_q.flags_in;
    end
    out_d = {3'b000, flags_d, exe_q.cond_true, exe_q.result};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the NZCV condition-flag ALU stream block.
module tb;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxIdle     = 18;
  localparam int unsigned MaxPrinted  = 100;

  localparam logic [4:0] OpUnusedLo = 5'd18;
  localparam logic [4:0] OpUnusedHi = 5'd31;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNeg  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [3:0] FlN = 4'b1 << awcf_pkg::FlagNBit;
  localparam logic [3:0] FlZ = 4'b1 << awcf_pkg::FlagZBit;
  localparam logic [3:0] FlC = 4'b1 << awcf_pkg::FlagCBit;
  localparam logic [3:0] FlV = 4'b1 << awcf_pkg::FlagVBit;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
  } cond_code_e;

  typedef struct {
    logic [4:0]  op;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [5:0]  hw;
    logic        set_fl;
    logic [3:0]  cc;
    logic [3:0]  fl;
  } alu_req_t;

  typedef struct {
    logic [63:0] value;
    logic        cond;
    logic [3:0]  flags;
  } alu_resp_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [awcf_pkg::InTdataW-1:0]  s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [awcf_pkg::OutTdataW-1:0] m_axis_tdata_o;

  alu_resp_t   awaited_results[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned hold_off_cycles;
  bit          src_idle;
  bit          sink_idle;

  alu_with_condition_flags DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic cond_passes(logic [3:0] cc, logic [3:0] fl);
    logic n, z, c, v, r;
    n = fl[awcf_pkg::FlagNBit];
    z = fl[awcf_pkg::FlagZBit];
    c = fl[awcf_pkg::FlagCBit];
    v = fl[awcf_pkg::FlagVBit];
    case (awcf_pkg::cond_grp_e'(cc[3:1]))
      awcf_pkg::CG_EQ: r = z;
      awcf_pkg::CG_CS: r = c;
      awcf_pkg::CG_MI: r = n;
      awcf_pkg::CG_VS: r = v;
      awcf_pkg::CG_HI: r = c && !z;
      awcf_pkg::CG_GE: r = (n == v);
      awcf_pkg::CG_GT: r = !z && (n == v);
      default: return 1'b1;
    endcase
    return cc[0] ? !r : r;
  endfunction

  function automatic alu_resp_t compute_alu(alu_req_t r);
    alu_resp_t   o;
    logic [64:0] sum;
    logic [63:0] y;
    logic [5:0]  sh;
    logic        ovf;
    logic        arith;
    sum   = '0;
    y     = '0;
    ovf   = 1'b0;
    arith = 1'b0;
    sh    = r.opb[5:0];
    o.cond = cond_passes(r.cc, r.fl);
    case (r.op) inside
      awcf_pkg::OP_ADD, awcf_pkg::OP_SUB: begin
        y = (r.op == awcf_pkg::OP_SUB) ? ~r.opb : r.opb;
        sum = {1'b0, r.opa} + {1'b0, y} + {64'd0, r.op == awcf_pkg::OP_SUB};
        o.value = sum[63:0];
        ovf = (r.opa[63] == y[63]) && (sum[63] != r.opa[63]);
        arith = 1'b1;
      end
      awcf_pkg::OP_ORN:   o.value = r.opa | ~r.opb;
      awcf_pkg::OP_OR:    o.value = r.opa | r.opb;
      awcf_pkg::OP_XOR:   o.value = r.opa ^ r.opb;
      awcf_pkg::OP_AND:   o.value = r.opa & r.opb;
      awcf_pkg::OP_MOV:   o.value = r.opa | (r.opb << r.hw);
      awcf_pkg::OP_MOVK:  o.value = (r.opa & ~(awcf_pkg::HalfMask << r.hw)) | (r.opb << r.hw);
      awcf_pkg::OP_LSL:   o.value = r.opa << sh;
      awcf_pkg::OP_LSR:   o.value = r.opa >> sh;
      awcf_pkg::OP_ASR:   o.value = $signed(r.opa) >>> sh;
      awcf_pkg::OP_PASS:  o.value = r.opa;
      awcf_pkg::OP_CSEL:  o.value = o.cond ? r.opa : r.opb;
      awcf_pkg::OP_CSINV: o.value = o.cond ? r.opa : ~r.opb;
      awcf_pkg::OP_CSINC: o.value = o.cond ? r.opa : r.opb + 64'd1;
      awcf_pkg::OP_CSNEG: o.value = o.cond ? r.opa : 64'd0 - r.opb;
      awcf_pkg::OP_CBZ: begin
        o.value = r.opa;
        o.cond = (r.opa == '0);
      end
      awcf_pkg::OP_CBNZ: begin
        o.value = r.opa;
        o.cond = (r.opa != '0);
      end
      default:  o.value = '0;
    endcase
    if (r.set_fl) begin
      o.flags = '0;
      o.flags[awcf_pkg::FlagNBit] = o.value[63];
      o.flags[awcf_pkg::FlagZBit] = (o.value == '0);
      if (arith) begin
        o.flags[awcf_pkg::FlagCBit] = sum[64];
        o.flags[awcf_pkg::FlagVBit] = ovf;
      end
    end else begin
      o.flags = r.fl;
    end
    return o;
  endfunction

  function automatic alu_req_t mk(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                  logic [5:0] hw, logic sf, logic [3:0] cc,
                                  logic [3:0] fl);
    alu_req_t r;
    r.op = op;
    r.opa = a;
    r.opb = b;
    r.hw = hw;
    r.set_fl = sf;
    r.cc = cc;
    r.fl = fl;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < MaxPrinted)
      $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // Offer one item, after a random gap when src_idle is set; hold it until accepted.
  task automatic send_op(alu_req_t r);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, r.fl, r.cc, r.set_fl, r.hw, r.opb, r.opa, r.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    awaited_results.push_back(compute_alu(r));
  endtask

  // Result side: check each accepted item, then draw the next stall.
  initial begin
    int unsigned stall_left;
    alu_resp_t   want;
    logic [63:0] got_value;
    logic        got_cond;
    logic [3:0]  got_flags;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_value = m_axis_tdata_o[63:0];
        got_cond  = m_axis_tdata_o[64];
        got_flags = m_axis_tdata_o[68:65];
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected item, result", got_value, 'x);
        end else begin
          want = awaited_results.pop_front();
          if (got_value !== want.value) report_mismatch("result", got_value, want.value);
          if (got_cond !== want.cond)
            report_mismatch("cond_true", {63'd0, got_cond}, {63'd0, want.cond});
          if (got_flags !== want.flags)
            report_mismatch("flags_out", {60'd0, got_flags}, {60'd0, want.flags});
        end
        stall_left = sink_idle ? $urandom_range(0, MaxIdle) : 0;
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("alu_with_condition_flags verification failed");
    $finish;
  end

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return AllOnes;
      2: return MinNeg;
      3: return MaxPos;
      4: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    r.op = ($urandom_range(0, 15) == 0)
           ? 5'($urandom_range(OpUnusedLo, OpUnusedHi))
           : 5'($urandom_range(awcf_pkg::OP_ADD, awcf_pkg::OP_CBNZ));
    r.opa = rand_operand();
    r.opb = ($urandom_range(0, 7) == 0) ? r.opa : rand_operand();
    r.hw = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'(16 * $urandom_range(0, 3));
    r.set_fl = 1'($urandom_range(0, 1));
    r.cc = 4'($urandom_range(0, 15));
    r.fl = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Extremes, every operation and the corner cases, one or more items per operation.
  task automatic test_directed();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_op(mk(awcf_pkg::OP_ADD, AllOnes, 64'd1, 6'd0, 1'b1, CC_AL, 4'h0));
    send_op(mk(awcf_pkg::OP_ADD, MaxPos, 64'd1, 6'd0, 1'b1, CC_EQ, FlZ));
    send_op(mk(awcf_pkg::OP_SUB, 64'd0, 64'd1, 6'd0, 1'b1, CC_NE, FlC));
    send_op(mk(awcf_pkg::OP_SUB, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 6'd0,
               1'b1, CC_CS, FlN));
    send_op(mk(awcf_pkg::OP_SUB, MinNeg, 64'd1, 6'd0, 1'b1, CC_CC, FlV));
    send_op(mk(awcf_pkg::OP_ORN, 64'd0, AllOnes, 6'd0, 1'b1, CC_MI, 4'hF));
    send_op(mk(awcf_pkg::OP_OR, 64'h00FF_00FF_00FF_00FF, 64'hF0F0_F0F0_F0F0_F0F0, 6'd0,
               1'b0, CC_PL, 4'hF));
    send_op(mk(awcf_pkg::OP_XOR, AllOnes, 64'h5555_5555_5555_5555, 6'd0, 1'b1, CC_VS,
               FlN | FlV));
    send_op(mk(awcf_pkg::OP_AND, AllOnes, MinNeg, 6'd0, 1'b1, CC_VC, FlV));
    send_op(mk(awcf_pkg::OP_MOV, 64'd0, 64'hFFFF, 6'd48, 1'b1, CC_HI, FlC));
    send_op(mk(awcf_pkg::OP_MOV, 64'h1, AllOnes, 6'd7, 1'b1, CC_LS, FlC | FlZ));
    // Wide movk operand is not trimmed to a halfword.
    send_op(mk(awcf_pkg::OP_MOVK, AllOnes, 64'h1_2345, 6'd60, 1'b1, CC_GE, FlN));
    send_op(mk(awcf_pkg::OP_MOVK, AllOnes, 64'h0, 6'd63, 1'b0, CC_LT, FlN | FlV));
    send_op(mk(awcf_pkg::OP_MOVK, 64'h0123_4567_89AB_CDEF, 64'hBEEF, 6'd16, 1'b1, CC_GT,
               FlZ));
    send_op(mk(awcf_pkg::OP_LSL, 64'd1, AllOnes, 6'd0, 1'b1, CC_LE, FlZ | FlN));
    send_op(mk(awcf_pkg::OP_LSR, AllOnes, 64'h40, 6'd0, 1'b1, CC_NV, 4'h0));
    send_op(mk(awcf_pkg::OP_ASR, MinNeg, 64'd63, 6'd0, 1'b1, CC_AL, 4'h0));
    send_op(mk(awcf_pkg::OP_ASR, MaxPos, 64'd1, 6'd0, 1'b1, CC_AL, 4'h0));
    send_op(mk(awcf_pkg::OP_PASS, 64'd0, AllOnes, 6'h3F, 1'b1, CC_EQ, 4'h0));
    send_op(mk(awcf_pkg::OP_CSEL, 64'hA, 64'hB, 6'd0, 1'b1, CC_EQ, FlZ));
    send_op(mk(awcf_pkg::OP_CSINV, 64'hA, 64'hB, 6'd0, 1'b1, CC_NE, FlZ));
    send_op(mk(awcf_pkg::OP_CSINC, 64'hA, AllOnes, 6'd0, 1'b1, CC_GT, FlN));
    send_op(mk(awcf_pkg::OP_CSNEG, 64'hA, MinNeg, 6'd0, 1'b1, CC_HI, FlZ | FlC));
    send_op(mk(awcf_pkg::OP_CBZ, 64'd0, 64'd0, 6'd0, 1'b1, CC_NV, 4'hF));
    send_op(mk(awcf_pkg::OP_CBNZ, 64'd0, 64'd5, 6'd0, 1'b0, CC_AL, 4'h0));
    send_op(mk(OpUnusedHi, AllOnes, AllOnes, 6'h3F, 1'b1, CC_LE, 4'hF));
  endtask

  // Stall the output while the input keeps offering, so the pipe fills.
  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_off_cycles = 120;
    repeat (40) send_op(rand_req());
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_idle  = ($urandom_range(0, 2) != 0);
        sink_idle = ($urandom_range(0, 2) != 0);
      end
      send_op(rand_req());
    end
  endtask

  initial begin
    mismatch_cnt    = 0;
    hold_off_cycles = 0;
    src_idle        = 1'b0;
    sink_idle       = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(600);
    s_axis_tvalid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("alu_with_condition_flags verification clean");
    end else begin
      $display("alu_with_condition_flags verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/awcf_pkg.sv
hw/rtl/alu_with_condition_flags.sv
sim/tb.sv
